// File: rtl/ufsa_pkg.sv
// Package for the unit-fraction sum accumulator.
// Holds widths, request structs, controller command/status types.
// No dependencies.
package ufsa_pkg;

  localparam int DEN_WIDTH = 16;
  localparam int SUM_WIDTH = 32;
  localparam int MUL_W     = SUM_WIDTH + DEN_WIDTH;
  localparam int PROD_W    = MUL_W + 1;
  localparam int K_W       = $clog2(PROD_W);
  localparam int CNT_W     = $clog2(PROD_W + 1);

  typedef struct packed {
    logic [DEN_WIDTH-1:0] denominator;
    logic                 last_of_set;
  } in_req_t;

  typedef struct packed {
    logic [SUM_WIDTH-1:0] sum_numerator;
    logic [SUM_WIDTH-1:0] sum_denominator;
    logic                 overflow;
    logic                 set_done;
  } out_req_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_done;
  } sts_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_GCD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

// File: rtl/ufsa_ctrl.sv
// Controller FSM for the unit-fraction sum accumulator.
// Sequences multiply, binary gcd, division and commit. Uses ufsa_pkg.
module ufsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_free,
  input  ufsa_pkg::sts_t  sts,
  output ufsa_pkg::cmd_t  cmd
);
  import ufsa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.den_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ufsa_dp.sv
// Datapath for the unit-fraction sum accumulator.
// Running sum, cross-product multipliers, binary gcd and two restoring
// dividers sharing one divisor. Uses ufsa_pkg.
module ufsa_dp (
  input  logic               clk,
  input  logic               rst,
  input  ufsa_pkg::cmd_t     cmd,
  input  ufsa_pkg::in_req_t  in_req,
  output ufsa_pkg::sts_t     sts,
  output ufsa_pkg::out_req_t res
);
  import ufsa_pkg::*;

  logic [SUM_WIDTH-1:0] acc_num, acc_den;
  logic                 sticky;

  logic [DEN_WIDTH-1:0] den_q;
  logic                 last_q;

  logic [PROD_W-1:0]    num_w, den_w;
  logic [PROD_W-1:0]    ga, gb;
  logic [K_W-1:0]       gk;
  logic [PROD_W-1:0]    divisor;
  logic [PROD_W-1:0]    rem_n, rem_d, quo_n, quo_d;
  logic [CNT_W-1:0]     cnt;

  logic [MUL_W-1:0]     prod_n, prod_d;
  logic [PROD_W-1:0]    mul_num, mul_den;
  logic [PROD_W:0]      trial_n, trial_d;
  logic                 fit;
  logic [SUM_WIDTH-1:0] new_num, new_den;
  logic                 new_ovf;

  assign prod_n  = MUL_W'(acc_num) * MUL_W'(den_q);
  assign prod_d  = MUL_W'(acc_den) * MUL_W'(den_q);
  assign mul_num = PROD_W'(prod_n) + PROD_W'(acc_den);
  assign mul_den = PROD_W'(prod_d);

  assign trial_n = {rem_n, quo_n[PROD_W-1]};
  assign trial_d = {rem_d, quo_d[PROD_W-1]};

  assign sts.den_zero = (den_q == '0);
  assign sts.gcd_done = (ga == '0) || (gb == '0);
  assign sts.div_done = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_q  <= in_req.denominator;
      last_q <= in_req.last_of_set;
    end
    if (cmd.mul) begin
      num_w <= mul_num;
      den_w <= mul_den;
      ga    <= mul_num;
      gb    <= mul_den;
      gk    <= '0;
    end else if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        gk <= gk + K_W'(1);
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= (ga - gb) >> 1;
      end else begin
        gb <= (gb - ga) >> 1;
      end
    end
    if (cmd.div_init) begin
      divisor <= (ga | gb) << gk;
      rem_n   <= '0;
      rem_d   <= '0;
      quo_n   <= num_w;
      quo_d   <= den_w;
    end else if (cmd.div_step) begin
      if (trial_n >= {1'b0, divisor}) begin
        rem_n <= PROD_W'(trial_n - {1'b0, divisor});
        quo_n <= {quo_n[PROD_W-2:0], 1'b1};
      end else begin
        rem_n <= PROD_W'(trial_n);
        quo_n <= {quo_n[PROD_W-2:0], 1'b0};
      end
      if (trial_d >= {1'b0, divisor}) begin
        rem_d <= PROD_W'(trial_d - {1'b0, divisor});
        quo_d <= {quo_d[PROD_W-2:0], 1'b1};
      end else begin
        rem_d <= PROD_W'(trial_d);
        quo_d <= {quo_d[PROD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_init) begin
      cnt <= CNT_W'(PROD_W);
    end else if (cmd.div_step) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign fit = (quo_n[PROD_W-1:SUM_WIDTH] == '0) && (quo_d[PROD_W-1:SUM_WIDTH] == '0);

  always_comb begin
    new_num = acc_num;
    new_den = acc_den;
    new_ovf = sticky;
    if (!sts.den_zero) begin
      if (fit) begin
        new_num = quo_n[SUM_WIDTH-1:0];
        new_den = quo_d[SUM_WIDTH-1:0];
      end else begin
        new_ovf = 1'b1;
      end
    end
  end

  assign res.sum_numerator   = new_num;
  assign res.sum_denominator = new_den;
  assign res.overflow        = new_ovf;
  assign res.set_done        = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num <= '0;
      acc_den <= SUM_WIDTH'(1);
      sticky  <= 1'b0;
    end else if (cmd.commit) begin
      if (last_q) begin
        acc_num <= '0;
        acc_den <= SUM_WIDTH'(1);
        sticky  <= 1'b0;
      end else begin
        acc_num <= new_num;
        acc_den <= new_den;
        sticky  <= new_ovf;
      end
    end
  end

endmodule

// File: rtl/unit_fraction_sum_accumulator.sv
// A zero denominator goes straight to the result; otherwise a request takes
// G binary gcd steps (at most 97 for 49-bit operands) and 49 division steps.
// A new request is taken only after the previous result is committed, but it
// is taken while that result still waits for output.
// Synchronous active-high reset: sum 0/1, overflow clear, no result pending.
// Top level; uses ufsa_pkg, ufsa_ctrl, ufsa_dp.
module unit_fraction_sum_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ufsa_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output ufsa_pkg::out_req_t out_req
);
  import ufsa_pkg::*;

  cmd_t     cmd;
  sts_t     sts;
  out_req_t res;
  logic     out_free;

  assign out_free = !out_valid || !out_stall;

  ufsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  ufsa_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .in_req (in_req),
    .sts    (sts),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_req <= res;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still in flight");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_req.sum_denominator != '0)
    else $error("zero sum denominator on output");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> out_free)
    else $error("result committed over a pending output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// File: tb/tb_top.sv
// Self-checking bench for unit_fraction_sum_accumulator: running sums of 1/d,
// gcd reduction, sticky overflow and set closing, under random idle and stall.
// Depends on ufsa_pkg and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ufsa_pkg::*;

  localparam int N_ITEMS    = 1500;
  localparam int PAUSE_AT   = 750;
  localparam int HOLD_AT    = 400;
  localparam int LONG_HOLD  = 1500;
  localparam int DRAIN      = 400;
  localparam int IDLE_LIMIT = 10000;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_req_t want;
  } row_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_req;

  logic [SUM_WIDTH-1:0] acc_num;
  logic [SUM_WIDTH-1:0] acc_den;
  logic                 acc_ovf;

  out_req_t    pending_sums [$];
  row_t        directed_rows [$];
  int unsigned sent;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          tx_quiet;
  bit          rx_quiet;

  unit_fraction_sum_accumulator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_req_t add_unit_fraction(in_req_t req);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] rn;
    logic [63:0] rd;
    out_req_t    res;
    if (req.denominator != '0) begin
      num = 64'(acc_num) * 64'(req.denominator) + 64'(acc_den);
      den = 64'(acc_den) * 64'(req.denominator);
      a = num;
      b = den;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      rn = num / a;
      rd = den / a;
      if ((rn >> SUM_WIDTH) != 0 || (rd >> SUM_WIDTH) != 0) begin
        acc_ovf = 1'b1;
      end else begin
        acc_num = rn[SUM_WIDTH-1:0];
        acc_den = rd[SUM_WIDTH-1:0];
      end
    end
    res.sum_numerator   = acc_num;
    res.sum_denominator = acc_den;
    res.overflow        = acc_ovf;
    res.set_done        = req.last_of_set;
    if (req.last_of_set) begin
      acc_num = '0;
      acc_den = SUM_WIDTH'(1);
      acc_ovf = 1'b0;
    end
    return res;
  endfunction

  task automatic plan_row(input logic [DEN_WIDTH-1:0] den, input logic last,
                          input bit typed = 1'b0, input logic [31:0] n = 0,
                          input logic [31:0] d = 1, input logic ovf = 1'b0);
    row_t row;
    row.req.denominator      = den;
    row.req.last_of_set      = last;
    row.typed                = typed;
    row.want.sum_numerator   = n;
    row.want.sum_denominator = d;
    row.want.overflow        = ovf;
    row.want.set_done        = last;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(input in_req_t req, input bit typed, input out_req_t want);
    int unsigned gap;
    out_req_t    pred;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = add_unit_fraction(req);
    pending_sums.push_back(typed ? want : pred);
    sent++;
    @(negedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_sums.size() == 0) begin
          $error("result with no request pending: %0d/%0d",
                 out_req.sum_numerator, out_req.sum_denominator);
          mismatches++;
        end else begin
          check_field("sum_numerator", pending_sums[0].sum_numerator,
                      out_req.sum_numerator);
          check_field("sum_denominator", pending_sums[0].sum_denominator,
                      out_req.sum_denominator);
          check_field("overflow", 32'(pending_sums[0].overflow), 32'(out_req.overflow));
          check_field("set_done", 32'(pending_sums[0].set_done), 32'(out_req.set_done));
          void'(pending_sums.pop_front());
        end
      end
    end
  end

  initial begin : sink
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    rx_quiet = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      hold = (taken == HOLD_AT) ? LONG_HOLD : (rx_quiet ? 0 : $urandom_range(0, 11));
      repeat (hold) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : source
    in_req_t     req;
    int unsigned set_len;
    int unsigned style;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_req      = '0;
    out_stall   = 1'b0;
    tx_quiet    = 1'b0;
    sent        = 0;
    mismatches  = 0;
    idle_cycles = 0;
    acc_num     = '0;
    acc_den     = SUM_WIDTH'(1);
    acc_ovf     = 1'b0;

    plan_row(16'd0,     1'b0, 1'b1, 0, 1, 1'b0);
    plan_row(16'd1,     1'b1, 1'b1, 1, 1, 1'b0);
    plan_row(16'd65535, 1'b0, 1'b1, 1, 65535, 1'b0);
    plan_row(16'd65535, 1'b1, 1'b1, 2, 65535, 1'b0);
    plan_row(16'd2,     1'b0, 1'b1, 1, 2, 1'b0);
    plan_row(16'd3,     1'b0, 1'b1, 5, 6, 1'b0);
    plan_row(16'd6,     1'b0, 1'b1, 1, 1, 1'b0);
    plan_row(16'd0,     1'b0, 1'b1, 1, 1, 1'b0);
    plan_row(16'd0,     1'b1, 1'b1, 1, 1, 1'b0);
    // two large coprime terms still fit, the third overflows and the sum holds
    plan_row(16'd65535, 1'b0);
    plan_row(16'd65534, 1'b0);
    plan_row(16'd65533, 1'b0);
    plan_row(16'd4,     1'b0);
    plan_row(16'd0,     1'b0);
    plan_row(16'd1,     1'b1);
    plan_row(16'd7,     1'b0, 1'b1, 1, 7, 1'b0);
    plan_row(16'd1,     1'b0, 1'b1, 8, 7, 1'b0);
    plan_row(16'h8000,  1'b0);
    plan_row(16'h5555,  1'b0);
    plan_row(16'hAAAA,  1'b1);
    plan_row(16'd1,     1'b1, 1'b1, 1, 1, 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    while (sent < N_ITEMS) begin
      if ($urandom_range(0, 15) == 0) tx_quiet = !tx_quiet;
      set_len = $urandom_range(1, 12);
      style   = $urandom_range(0, 9);
      for (int k = 0; k < set_len; k++) begin
        if (sent == PAUSE_AT) begin
          in_valid <= 1'b0;
          while (pending_sums.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        case (style) inside
          [0:4]:   req.denominator = DEN_WIDTH'($urandom_range(1, 24));
          [5:7]:   req.denominator = DEN_WIDTH'($urandom_range(1, 4095));
          default: req.denominator = DEN_WIDTH'($urandom());
        endcase
        if ($urandom_range(0, 19) == 0) req.denominator = '0;
        // style 9 is noise: set boundaries fall at random
        req.last_of_set = (style == 9) ? 1'($urandom_range(0, 1)) : (k == set_len - 1);
        offer(req, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ufsa_pkg.sv
rtl/ufsa_ctrl.sv
rtl/ufsa_dp.sv
rtl/unit_fraction_sum_accumulator.sv
tb/tb_top.sv
